// ===== hdl/mjq_pkg.sv =====
// Shared constants and types for the minimum-jerk quintic time scaling core.
package mjq_pkg;

    localparam int WORD_W    = 32;
    localparam int MUL_W     = 160;
    localparam int MUL_WORDS = 5;
    localparam int NUM_W     = 132;
    localparam int DEN_W     = 160;
    localparam int QUO_W     = 64;
    localparam int STEP_W    = 8;

    localparam logic [MUL_W-1:0] TGT_VEL  = 160'd15 << 45;
    localparam logic [MUL_W-1:0] TGT_ACC  = 160'd24797005245 << 32;
    localparam logic [MUL_W-1:0] TGT_JERK = 160'd60 << 80;

    localparam logic [63:0] RATIO_INF = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MAG   = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic REG_JOINT_COUNT = 1'b0;
    localparam logic REG_ZERO_THRESH = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mjq_div_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } mjq_div_sts_t;

endpackage

// ===== hdl/mjq_in_if.sv =====
// Joint input channel: positions and limits of one joint.
interface mjq_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [31:0]        vel_limit;
    logic [31:0]        acc_limit;
    logic [31:0]        jerk_limit;

    modport source (output valid, output start_pos, output end_pos, output vel_limit,
                    output acc_limit, output jerk_limit, input ready);
    modport sink (input valid, input start_pos, input end_pos, input vel_limit,
                  input acc_limit, input jerk_limit, output ready);
endinterface

// ===== hdl/mjq_out_if.sv =====
// Polynomial output channel: duration and quintic coefficients of one joint.
interface mjq_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         joint_index;
    logic [31:0]        duration;
    logic signed [31:0] coef_zero;
    logic signed [63:0] coef_three;
    logic signed [63:0] coef_four;
    logic signed [63:0] coef_five;
    logic               last_joint;

    modport source (output valid, output joint_index, output duration, output coef_zero,
                    output coef_three, output coef_four, output coef_five,
                    output last_joint, input ready);
    modport sink (input valid, input joint_index, input duration, input coef_zero,
                  input coef_three, input coef_four, input coef_five,
                  input last_joint, output ready);
endinterface

// ===== hdl/mjq_div.sv =====
// Bit-serial restoring divider with quotient overflow flag.
module mjq_div
    import mjq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mjq_div_ctl_t     ctl,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quot,
    output mjq_div_sts_t     sts
);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quot_reg;
    logic              ovf_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
                cnt_reg  <= ctl.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg  <= num_reg << 1;
                rem_reg  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                quot_reg <= {quot_reg[QUO_W-2:0], ge};
                ovf_reg  <= ovf_reg | quot_reg[QUO_W-1];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot     = quot_reg;
    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg | quot_reg[QUO_W-1];

endmodule

// ===== hdl/mjq_mul.sv =====
// Word-serial multiplier: 160-bit operand times 32-bit word, one word a cycle.
module mjq_mul
    import mjq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [MUL_W-1:0]  prod
);

    logic [MUL_W-1:0]    a_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [MUL_W-1:0]    res_reg;
    logic [WORD_W-1:0]   carry_reg;
    logic [2:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [2*WORD_W-1:0] cur;

    assign cur = a_reg[WORD_W-1:0] * b_reg + (2*WORD_W)'(carry_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            res_reg   <= '0;
            carry_reg <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg     <= a;
                b_reg     <= b;
                res_reg   <= '0;
                carry_reg <= '0;
                cnt_reg   <= 3'(MUL_WORDS);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                res_reg   <= {cur[WORD_W-1:0], res_reg[MUL_W-1:WORD_W]};
                a_reg     <= a_reg >> WORD_W;
                carry_reg <= cur[2*WORD_W-1:WORD_W];
                cnt_reg   <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = res_reg;

endmodule

// ===== hdl/min_jerk_quintic_time_scaling_core.sv =====
// Top level of the minimum-jerk quintic time scaling core.
//
// joint_in carries one joint per transaction (positions and limits). After
// joint_count joints the core finds the common duration T and sends one
// transaction per joint on poly_out (T and quintic coefficients), the last
// one flagged by last_joint. joint_count and zero_threshold sit on the APB
// port at byte addresses 0 and 4; write them only while the core is idle.
// Load: a still joint goes straight to the check; a moving one runs three
// 64-step divisions on the shared serial divider.
// Duration: binary search of 32 steps for each of the three limits on the
// shared word-serial multiplier, then T^3..T^5 on the same multiplier.
// Per joint result: three 132-step divisions.
// joint_in.ready is high only while no work is pending. A finished result
// waits in the output register; a stalled receiver holds the core before the
// next result, and the core takes a new joint while the last result waits.
// Reset clears the limit minimums, the load count and the registers
// (joint_count = 1, zero_threshold = 1).
module min_jerk_quintic_time_scaling_core
    import mjq_pkg::*;
#(
    parameter int MAX_JOINTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    mjq_in_if.sink      joint_in,
    mjq_out_if.source   poly_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_JOINTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_RMUL   = 4'd4;
    localparam logic [3:0] S_POW    = 4'd5;
    localparam logic [3:0] S_LOADJ  = 4'd6;
    localparam logic [3:0] S_CSTART = 4'd7;
    localparam logic [3:0] S_CDIV   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    localparam logic [1:0] SEL_VEL  = 2'd0;
    localparam logic [1:0] SEL_ACC  = 2'd1;
    localparam logic [1:0] SEL_JERK = 2'd2;

    // storage
    logic [31:0] start_mem [MAX_JOINTS];
    logic [32:0] disp_mem  [MAX_JOINTS];

    logic [3:0]       state_reg;
    logic [1:0]       sel_reg;
    logic [CNT_W-1:0] loaded_count_reg;
    logic [CNT_W-1:0] k_reg;
    logic [63:0]      min_vel_reg;
    logic [63:0]      min_acc_reg;
    logic [63:0]      min_jerk_reg;
    logic [3:0]       joint_count_reg;
    logic [15:0]      zero_thresh_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      jerk_reg;
    logic [32:0]      mag_reg;
    logic             moving_reg;
    logic [1:0]       power_reg;
    logic [1:0]       mcnt_reg;
    logic [2:0]       ecnt_reg;
    logic [31:0]      lo_reg;
    logic [31:0]      hi_reg;
    logic [31:0]      mid_reg;
    logic [31:0]      t_reg;
    logic [MUL_W-1:0] m3_reg;
    logic [MUL_W-1:0] m4_reg;
    logic [MUL_W-1:0] m5_reg;
    logic [31:0]      jstart_reg;
    logic [32:0]      jdisp_reg;
    logic [63:0]      c3_reg;
    logic [63:0]      c4_reg;
    logic [63:0]      c5_reg;

    mjq_div_ctl_t     div_ctl_reg;
    logic [NUM_W-1:0] div_num_reg;
    logic [DEN_W-1:0] div_den_reg;
    logic [QUO_W-1:0] div_quot;
    mjq_div_sts_t     div_sts;

    logic              mul_start_reg;
    logic [MUL_W-1:0]  mul_a_reg;
    logic [WORD_W-1:0] mul_b_reg;
    logic              mul_done;
    logic [MUL_W-1:0]  mul_prod;

    logic             out_valid_reg;
    logic [2:0]       out_idx_reg;
    logic [31:0]      out_dur_reg;
    logic [31:0]      out_c0_reg;
    logic [63:0]      out_c3_reg;
    logic [63:0]      out_c4_reg;
    logic [63:0]      out_c5_reg;
    logic             out_last_reg;

    logic             in_fire;
    logic [32:0]      disp_in;
    logic [32:0]      mag_in;
    logic [IDX_W-1:0] load_idx;
    logic [3:0]       eff_count;
    logic [31:0]      mid_val;
    logic [31:0]      t_new;
    logic [63:0]      ratio_sel;
    logic [MUL_W-1:0] tgt_sel;
    logic [31:0]      lim_sel;
    logic [32:0]      magk;
    logic [NUM_W-1:0] cnum3;
    logic [NUM_W-1:0] cnum4;
    logic [NUM_W-1:0] cnum5;
    logic [63:0]      qmag;
    logic [63:0]      qneg;
    logic             cfg_wr;

    mjq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .quot  (div_quot),
        .sts   (div_sts)
    );

    mjq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign joint_in.ready = (state_reg == S_IDLE);
    assign in_fire        = joint_in.valid & joint_in.ready;

    assign disp_in  = {joint_in.end_pos[31], joint_in.end_pos}
                    - {joint_in.start_pos[31], joint_in.start_pos};
    assign mag_in   = disp_in[32] ? (~disp_in + 33'd1) : disp_in;
    assign load_idx = IDX_W'(loaded_count_reg);

    always_comb
    begin
        if (joint_count_reg == 4'd0)
            eff_count = 4'd1;
        else if (joint_count_reg > 4'(MAX_JOINTS))
            eff_count = 4'(MAX_JOINTS);
        else
            eff_count = joint_count_reg;
    end

    assign mid_val = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign t_new   = (lo_reg > t_reg) ? lo_reg : t_reg;

    always_comb
    begin
        case (power_reg)
            2'd1:
            begin
                ratio_sel = min_vel_reg;
                tgt_sel   = TGT_VEL;
            end
            2'd2:
            begin
                ratio_sel = min_acc_reg;
                tgt_sel   = TGT_ACC;
            end
            default:
            begin
                ratio_sel = min_jerk_reg;
                tgt_sel   = TGT_JERK;
            end
        endcase
    end

    assign lim_sel = (sel_reg == SEL_VEL) ? acc_reg : jerk_reg;

    assign magk  = jdisp_reg[32] ? (~jdisp_reg + 33'd1) : jdisp_reg;
    assign cnum3 = NUM_W'(37'(magk) * 37'd10) << 64;
    assign cnum4 = NUM_W'(37'(magk) * 37'd15) << 80;
    assign cnum5 = NUM_W'(37'(magk) * 37'd6) << 96;

    assign qmag = div_sts.ovf ? SAT_MAG : {1'b0, div_quot[QUO_W-2:0]};
    assign qneg = ~qmag + 64'd1;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ZERO_THRESH) ? {16'd0, zero_thresh_reg}
                                                  : {28'd0, joint_count_reg};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            start_mem[load_idx] <= joint_in.start_pos;
            disp_mem[load_idx]  <= disp_in;
        end
        if (state_reg == S_LOADJ)
        begin
            jstart_reg <= start_mem[IDX_W'(k_reg)];
            jdisp_reg  <= disp_mem[IDX_W'(k_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sel_reg          <= SEL_VEL;
            loaded_count_reg <= '0;
            k_reg            <= '0;
            min_vel_reg      <= RATIO_INF;
            min_acc_reg      <= RATIO_INF;
            min_jerk_reg     <= RATIO_INF;
            joint_count_reg  <= 4'd1;
            zero_thresh_reg  <= 16'd1;
            acc_reg          <= '0;
            jerk_reg         <= '0;
            mag_reg          <= '0;
            moving_reg       <= 1'b0;
            power_reg        <= 2'd1;
            mcnt_reg         <= '0;
            ecnt_reg         <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            mid_reg          <= '0;
            t_reg            <= '0;
            m3_reg           <= '0;
            m4_reg           <= '0;
            m5_reg           <= '0;
            c3_reg           <= '0;
            c4_reg           <= '0;
            c5_reg           <= '0;
            div_ctl_reg      <= '0;
            div_num_reg      <= '0;
            div_den_reg      <= '0;
            mul_start_reg    <= 1'b0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_idx_reg      <= '0;
            out_dur_reg      <= '0;
            out_c0_reg       <= '0;
            out_c3_reg       <= '0;
            out_c4_reg       <= '0;
            out_c5_reg       <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            div_ctl_reg.start <= 1'b0;
            mul_start_reg     <= 1'b0;
            if (poly_out.ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                if (paddr[2] == REG_ZERO_THRESH)
                    zero_thresh_reg <= pwdata[15:0];
                else
                    joint_count_reg <= pwdata[3:0];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        acc_reg          <= joint_in.acc_limit;
                        jerk_reg         <= joint_in.jerk_limit;
                        mag_reg          <= mag_in;
                        loaded_count_reg <= loaded_count_reg + 1'b1;
                        if (mag_in > {17'd0, zero_thresh_reg})
                        begin
                            sel_reg           <= SEL_VEL;
                            div_num_reg       <= {joint_in.vel_limit, 100'd0};
                            div_den_reg       <= DEN_W'(mag_in);
                            div_ctl_reg.steps <= STEP_W'(64);
                            div_ctl_reg.start <= 1'b1;
                            state_reg         <= S_DIV;
                        end
                        else
                            state_reg <= S_CHECK;
                    end
                end

                S_DIV:
                begin
                    if (div_sts.done)
                    begin
                        case (sel_reg)
                            SEL_VEL:
                                if (div_quot < min_vel_reg)
                                    min_vel_reg <= div_quot;
                            SEL_ACC:
                                if (div_quot < min_acc_reg)
                                    min_acc_reg <= div_quot;
                            default:
                                if (div_quot < min_jerk_reg)
                                    min_jerk_reg <= div_quot;
                        endcase
                        if (sel_reg == SEL_JERK)
                            state_reg <= S_CHECK;
                        else
                        begin
                            sel_reg           <= sel_reg + 2'd1;
                            div_num_reg       <= {lim_sel, 100'd0};
                            div_den_reg       <= DEN_W'(mag_reg);
                            div_ctl_reg.start <= 1'b1;
                        end
                    end
                end

                S_CHECK:
                begin
                    if (4'(loaded_count_reg) < eff_count)
                        state_reg <= S_IDLE;
                    else
                    begin
                        t_reg <= '0;
                        k_reg <= '0;
                        if (min_vel_reg != RATIO_INF)
                        begin
                            moving_reg <= 1'b1;
                            power_reg  <= 2'd1;
                            lo_reg     <= '0;
                            hi_reg     <= '1;
                            state_reg  <= S_ROOT;
                        end
                        else
                        begin
                            moving_reg <= 1'b0;
                            state_reg  <= S_LOADJ;
                        end
                    end
                end

                S_ROOT:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg       <= mid_val;
                        mul_a_reg     <= MUL_W'(ratio_sel);
                        mul_b_reg     <= mid_val;
                        mul_start_reg <= 1'b1;
                        mcnt_reg      <= power_reg;
                        state_reg     <= S_RMUL;
                    end
                    else
                    begin
                        t_reg <= t_new;
                        if (power_reg == 2'd3)
                        begin
                            mul_a_reg     <= MUL_W'(1);
                            mul_b_reg     <= t_new;
                            mul_start_reg <= 1'b1;
                            ecnt_reg      <= 3'd1;
                            state_reg     <= S_POW;
                        end
                        else
                        begin
                            power_reg <= power_reg + 2'd1;
                            lo_reg    <= '0;
                            hi_reg    <= '1;
                        end
                    end
                end

                S_RMUL:
                begin
                    if (mul_done)
                    begin
                        if (mcnt_reg > 2'd1)
                        begin
                            mcnt_reg      <= mcnt_reg - 2'd1;
                            mul_a_reg     <= mul_prod;
                            mul_b_reg     <= mid_reg;
                            mul_start_reg <= 1'b1;
                        end
                        else
                        begin
                            if (mul_prod >= tgt_sel)
                                hi_reg <= mid_reg;
                            else
                                lo_reg <= mid_reg + 32'd1;
                            state_reg <= S_ROOT;
                        end
                    end
                end

                S_POW:
                begin
                    if (mul_done)
                    begin
                        case (ecnt_reg)
                            3'd3:    m3_reg <= mul_prod;
                            3'd4:    m4_reg <= mul_prod;
                            3'd5:    m5_reg <= mul_prod;
                            default: ;
                        endcase
                        if (ecnt_reg == 3'd5)
                            state_reg <= S_LOADJ;
                        else
                        begin
                            ecnt_reg      <= ecnt_reg + 3'd1;
                            mul_a_reg     <= mul_prod;
                            mul_b_reg     <= t_reg;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end

                S_LOADJ:
                    state_reg <= S_CSTART;

                S_CSTART:
                begin
                    if (moving_reg)
                    begin
                        sel_reg           <= SEL_VEL;
                        div_num_reg       <= cnum3;
                        div_den_reg       <= m3_reg;
                        div_ctl_reg.steps <= STEP_W'(NUM_W);
                        div_ctl_reg.start <= 1'b1;
                        state_reg         <= S_CDIV;
                    end
                    else
                    begin
                        c3_reg    <= '0;
                        c4_reg    <= '0;
                        c5_reg    <= '0;
                        state_reg <= S_EMIT;
                    end
                end

                S_CDIV:
                begin
                    if (div_sts.done)
                    begin
                        case (sel_reg)
                            SEL_VEL:
                            begin
                                c3_reg            <= jdisp_reg[32] ? qneg : qmag;
                                div_num_reg       <= cnum4;
                                div_den_reg       <= m4_reg;
                                div_ctl_reg.start <= 1'b1;
                                sel_reg           <= SEL_ACC;
                            end
                            SEL_ACC:
                            begin
                                c4_reg            <= jdisp_reg[32] ? qmag : qneg;
                                div_num_reg       <= cnum5;
                                div_den_reg       <= m5_reg;
                                div_ctl_reg.start <= 1'b1;
                                sel_reg           <= SEL_JERK;
                            end
                            default:
                            begin
                                c5_reg    <= jdisp_reg[32] ? qneg : qmag;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || poly_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= 3'(k_reg);
                        out_dur_reg   <= t_reg;
                        out_c0_reg    <= jstart_reg;
                        out_c3_reg    <= c3_reg;
                        out_c4_reg    <= c4_reg;
                        out_c5_reg    <= c5_reg;
                        out_last_reg  <= (k_reg + 1'b1 == loaded_count_reg);
                        if (k_reg + 1'b1 == loaded_count_reg)
                        begin
                            min_vel_reg      <= RATIO_INF;
                            min_acc_reg      <= RATIO_INF;
                            min_jerk_reg     <= RATIO_INF;
                            loaded_count_reg <= '0;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_LOADJ;
                        end
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign poly_out.valid       = out_valid_reg;
    assign poly_out.joint_index = out_idx_reg;
    assign poly_out.duration    = out_dur_reg;
    assign poly_out.coef_zero   = out_c0_reg;
    assign poly_out.coef_three  = out_c3_reg;
    assign poly_out.coef_four   = out_c4_reg;
    assign poly_out.coef_five   = out_c5_reg;
    assign poly_out.last_joint  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= CNT_W'(MAX_JOINTS))
        else $error("load count beyond joint storage");

    a_unit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_ctl_reg.start && mul_start_reg))
        else $error("divider and multiplier started together");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && loaded_count_reg == '0) |-> (min_vel_reg == RATIO_INF))
        else $error("limit minimum not cleared between runs");

    a_still_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dur_reg == 32'd0) |->
        (out_c3_reg == 64'd0 && out_c4_reg == 64'd0 && out_c5_reg == 64'd0))
        else $error("nonzero coefficient with zero duration");

endmodule

// ===== tb/mjq_poly_checker.sv =====
// Checker: predicts quintic trajectories from joint loads and compares poly_out transactions.
`timescale 1ns / 1ps
module mjq_poly_checker
    import mjq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mjq_in_if           jin,
    mjq_out_if          pout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending
);

    typedef struct {
        logic [2:0]  joint_index;
        logic [31:0] duration;
        logic [31:0] coef_zero;
        logic [63:0] coef_three;
        logic [63:0] coef_four;
        logic [63:0] coef_five;
        logic        last_joint;
    } poly_t;

    poly_t       expected_polys[$];
    logic [31:0] start_mem[8];
    longint      disp_mem[8];
    logic [63:0] vel_min, acc_min, jerk_min;
    int unsigned joints_loaded;
    logic [3:0]  joint_count;
    logic [15:0] zero_thresh;

    assign pending = expected_polys.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [31:0] least_duration(input logic [63:0] ratio, input int power,
                                                   input logic [255:0] target);
        longint unsigned lo, hi, mid;
        logic [255:0]    p;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            p = {192'b0, ratio};
            for (int k = 0; k < power; k++)
                p = p * {224'b0, mid[31:0]};
            if (p >= target)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo[31:0];
    endfunction

    function automatic logic [63:0] quintic_coef(input logic [63:0] mag, input int c,
                                                 input int shift, input logic [31:0] t,
                                                 input int power, input bit negative);
        logic [255:0] num, den, q;
        logic [63:0]  r;
        num = ({192'b0, mag} * c) << shift;
        den = 256'd1;
        for (int k = 0; k < power; k++)
            den = den * {224'b0, t};
        if (num >= (den << 63))
            r = SAT_MAG;
        else
        begin
            q = num / den;
            r = q[63:0];
        end
        return negative ? -r : r;
    endfunction

    task automatic predict_trajectory();
        longint      s, d, dk;
        logic [63:0] mag, mk, rv, ra, rj;
        int unsigned idx, eff;
        logic [31:0] tv, ta, tj, t;
        bit          moving;
        poly_t       p;
        s = longint'(jin.start_pos);
        d = longint'(jin.end_pos) - s;
        mag = d < 0 ? -d : d;
        idx = joints_loaded % 8;
        start_mem[idx] = jin.start_pos;
        disp_mem[idx] = d;
        if (mag > zero_thresh)
        begin
            rv = {jin.vel_limit, 32'b0} / mag;
            ra = {jin.acc_limit, 32'b0} / mag;
            rj = {jin.jerk_limit, 32'b0} / mag;
            if (rv < vel_min) vel_min = rv;
            if (ra < acc_min) acc_min = ra;
            if (rj < jerk_min) jerk_min = rj;
        end
        joints_loaded = idx + 1;
        eff = joint_count == 0 ? 1 : (joint_count > 8 ? 8 : joint_count);
        if (joints_loaded < eff)
            return;
        moving = vel_min != RATIO_INF;
        t = 0;
        if (moving)
        begin
            tv = least_duration(vel_min, 1, {96'b0, TGT_VEL});
            ta = least_duration(acc_min, 2, {96'b0, TGT_ACC});
            tj = least_duration(jerk_min, 3, {96'b0, TGT_JERK});
            t = tv;
            if (ta > t) t = ta;
            if (tj > t) t = tj;
        end
        for (int k = 0; k < joints_loaded; k++)
        begin
            dk = disp_mem[k];
            mk = dk < 0 ? -dk : dk;
            p.joint_index = k[2:0];
            p.duration = t;
            p.coef_zero = start_mem[k];
            p.coef_three = moving ? quintic_coef(mk, 10, 64, t, 3, dk < 0) : 64'b0;
            p.coef_four = moving ? quintic_coef(mk, 15, 80, t, 4, !(dk < 0)) : 64'b0;
            p.coef_five = moving ? quintic_coef(mk, 6, 96, t, 5, dk < 0) : 64'b0;
            p.last_joint = (k + 1 == joints_loaded);
            expected_polys.push_back(p);
        end
        vel_min = RATIO_INF;
        acc_min = RATIO_INF;
        jerk_min = RATIO_INF;
        joints_loaded = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        poly_t w;
        if (!rst_n)
        begin
            vel_min = RATIO_INF;
            acc_min = RATIO_INF;
            jerk_min = RATIO_INF;
            joints_loaded = 0;
            joint_count = 1;
            zero_thresh = 1;
            expected_polys.delete();
            error_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_JOINT_COUNT: joint_count = pwdata[3:0];
                    REG_ZERO_THRESH: zero_thresh = pwdata[15:0];
                    default: ;
                endcase
            end
            if (jin.valid && jin.ready)
                predict_trajectory();
            if (pout.valid && pout.ready)
            begin
                if (expected_polys.size() == 0)
                    report("unexpected transaction", 64'(pout.joint_index), 64'd0);
                else
                begin
                    w = expected_polys.pop_front();
                    if (pout.joint_index !== w.joint_index)
                        report("joint_index", pout.joint_index, w.joint_index);
                    if (pout.duration !== w.duration)
                        report("duration", pout.duration, w.duration);
                    if (pout.coef_zero !== w.coef_zero)
                        report("coef_zero", pout.coef_zero, w.coef_zero);
                    if (pout.coef_three !== w.coef_three)
                        report("coef_three", pout.coef_three, w.coef_three);
                    if (pout.coef_four !== w.coef_four)
                        report("coef_four", pout.coef_four, w.coef_four);
                    if (pout.coef_five !== w.coef_five)
                        report("coef_five", pout.coef_five, w.coef_five);
                    if (pout.last_joint !== w.last_joint)
                        report("last_joint", pout.last_joint, w.last_joint);
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top: joint stimulus, APB register writes and the final verdict.
`timescale 1ns / 1ps
module tb;
    import mjq_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE = 300;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          error_count;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          cycles = 0;
    int          sent;

    mjq_in_if  jin();
    mjq_out_if pout();

    min_jerk_quintic_time_scaling_core dut (
        .clk(clk), .rst_n(rst_n), .joint_in(jin), .poly_out(pout),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mjq_poly_checker chk (
        .clk(clk), .rst_n(rst_n), .jin(jin), .pout(pout),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .error_count(error_count), .pending(pending)
    );

    initial
    begin
        jin.valid = 0;
        jin.start_pos = 0;
        jin.end_pos = 0;
        jin.vel_limit = 1;
        jin.acc_limit = 1;
        jin.jerk_limit = 1;
        pout.ready = 0;
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        pout.ready <= rst_n && ($urandom_range(99) >= recv_idle);

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic send_joint(input logic [31:0] s, input logic [31:0] e, input logic [31:0] v,
                              input logic [31:0] a, input logic [31:0] j);
        while ($urandom_range(99) < send_idle)
        begin
            jin.valid <= 0;
            @(posedge clk);
        end
        jin.valid <= 1;
        jin.start_pos <= s;
        jin.end_pos <= e;
        jin.vel_limit <= v;
        jin.acc_limit <= a;
        jin.jerk_limit <= j;
        @(posedge clk);
        while (!jin.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        jin.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(3))
            0: return $urandom() | 1;
            1: return $urandom_range(32'h00FF_FFFF, 1);
            2: return $urandom_range(32'h0100_0000, 32'h0001_0000);
            default: return {2'($urandom_range(3)), 30'h0} | $urandom_range(32'h3FFF_FFFF, 1);
        endcase
    endfunction

    task automatic send_random(input logic [15:0] zt);
        logic [31:0] s, e;
        s = $urandom();
        case ($urandom_range(9))
            0, 1: e = $urandom();
            2: e = s + $urandom_range(zt);
            3: e = s;
            default: e = s + ($urandom_range(1) ? $urandom_range(32'h0100_0000, 1)
                                                : -$urandom_range(32'h0100_0000, 1));
        endcase
        send_joint(s, e, rand_limit(), rand_limit(), rand_limit());
    endtask

    initial
    begin
        logic [3:0]  jc;
        logic [15:0] zt;
        int          eff, part, phase_end;
        sent = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single joints under reset settings: still, at threshold, overflow, extremes
        send_joint(32'h0001_0000, 32'h0001_0000, 32'h1, 32'h1, 32'h1);
        send_joint(32'h0000_0005, 32'h0000_0006, 32'hFFFF_FFFF, 32'h1, 32'h1);
        send_joint(32'h0000_0000, 32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_joint(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h1);
        send_joint(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
        drain();
        reg_write(REG_JOINT_COUNT, 3);
        reg_write(REG_ZERO_THRESH, 16'hFFFF);
        send_joint(32'h0000_0000, 32'h0000_FFFF, 32'h1000, 32'h1000, 32'h1000);
        send_joint(32'h0010_0000, 32'h0000_FFFF, 32'h1000, 32'h1000, 32'h1000);
        send_joint(32'hFFFF_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 32'h1);
        drain();
        reg_write(REG_JOINT_COUNT, 0);
        reg_write(REG_ZERO_THRESH, 0);
        send_joint(32'h0000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        drain();
        reg_write(REG_JOINT_COUNT, 15);
        for (int k = 0; k < 8; k++)
            send_joint($urandom(), $urandom(), rand_limit(), rand_limit(), rand_limit());
        drain();
        // count lowered below the number already loaded
        reg_write(REG_JOINT_COUNT, 5);
        reg_write(REG_ZERO_THRESH, 1);
        for (int k = 0; k < 3; k++)
            send_random(1);
        jin.valid <= 0;
        repeat (SETTLE) @(posedge clk);
        reg_write(REG_JOINT_COUNT, 2);
        send_random(1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = phase == 0 ? 38 : (phase == 1 ? 88 : 0);
            recv_idle = phase == 0 ? 88 : (phase == 1 ? 38 : 0);
            phase_end = sent + 150;
            while (sent < phase_end)
            begin
                jc = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(3, 1));
                zt = $urandom_range(3) == 0 ? 16'($urandom_range(16'hFFFF))
                                            : 16'($urandom_range(4));
                reg_write(REG_JOINT_COUNT, jc);
                reg_write(REG_ZERO_THRESH, zt);
                eff = jc == 0 ? 1 : (jc > 8 ? 8 : jc);
                if (eff > 2 && $urandom_range(9) == 0)
                begin
                    part = $urandom_range(eff - 1, 1);
                    for (int k = 0; k < part; k++)
                        send_random(zt);
                    jin.valid <= 0;
                    repeat (SETTLE) @(posedge clk);
                    reg_write(REG_JOINT_COUNT, $urandom_range(part));
                    send_random(zt);
                end
                else
                    for (int k = 0; k < eff; k++)
                        send_random(zt);
                drain();
            end
        end

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
